// File: src/lste_pkg.sv
`default_nettype none

package lste_pkg;

  // Operation codes
  localparam logic [2:0] OP_INSTALL = 3'd0;
  localparam logic [2:0] OP_REMOVE  = 3'd1;
  localparam logic [2:0] OP_AGE     = 3'd2;
  localparam logic [2:0] OP_FLUSH   = 3'd3;
  localparam logic [2:0] OP_LOOKUP  = 3'd4;
  localparam logic [2:0] OP_CLEAR   = 3'd5;

  // Status codes
  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_STALE     = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_DONE      = 3'd5;

  localparam int unsigned  ID_SPAN     = 256;
  localparam int unsigned  CNT_W       = 9;
  localparam logic [15:0]  MAX_AGE_RST = 16'd3600;
  localparam logic [15:0]  AGE_SAT     = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  router_id;
    logic [31:0] seq_in;
    logic [15:0] age_in;
  } lste_in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             found;
    logic [31:0]      seq_out;
    logic [15:0]      age_out;
    logic             is_neighbour;
    logic [CNT_W-1:0] flushed_count;
    logic [31:0]      received_total;
    logic [31:0]      stale_total;
    logic [31:0]      duplicate_total;
  } lste_out_t;

  // One stored advertisement header
  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] age;
  } entry_t;

endpackage

`default_nettype wire

// File: src/link_state_table_engine_unit.sv
`default_nettype none
// Install, remove, lookup, clear: memory read on accept, then modify/write.
// No new item is taken until the result is loaded: input stalls outside idle.
// Age tick and flush: sweep all min(MAX_ROUTERS,256) entries, one per cycle.
// Reset clears valid bits, neighbour marks and counters at once; max_age resets to 3600.
// Stored sequence and age need no clearing pass: they are read only behind a valid bit.

module link_state_table_engine_unit #(
  parameter int unsigned MAX_ROUTERS = 256
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire lste_pkg::lste_in_t   in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output lste_pkg::lste_out_t       out_item_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [15:0]          cfg_data_i
);

  // Ids are 8 bits wide, so entries above 255 are never reachable
  localparam int unsigned DEPTH =
    (MAX_ROUTERS < lste_pkg::ID_SPAN) ? MAX_ROUTERS : lste_pkg::ID_SPAN;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_WRAP  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [15:0]             max_age_q;
  logic [DEPTH-1:0]        valid_q, valid_d;
  logic [DEPTH-1:0]        nbr_q, nbr_d;
  logic [31:0]             recv_q, recv_d;
  logic [31:0]             stale_q, stale_d;
  logic [31:0]             dup_q, dup_d;
  logic [2:0]              op_q;
  logic [IDX_W-1:0]        idx_q;
  logic                    in_range_q;
  logic [31:0]             seq_q;
  logic [15:0]             age_q;
  logic [IDX_W-1:0]        ptr_q, ptr_d;
  logic [lste_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                    out_valid_q;
  lste_pkg::lste_out_t     out_q, out_d;
  logic                    out_load;

  logic                    accept;
  logic                    out_free;
  logic                    is_sweep_op;
  logic                    found;
  logic                    mem_we, mem_re;
  logic [IDX_W-1:0]        mem_waddr, mem_raddr;
  lste_pkg::entry_t        mem_wdata, mem_rdata;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign is_sweep_op = (in_item_i.operation == lste_pkg::OP_AGE) ||
                       (in_item_i.operation == lste_pkg::OP_FLUSH);
  assign found       = in_range_q && valid_q[idx_q];

  // Entry storage
  lste_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Read address: target entry (entry 0 for a sweep) on accept, next entry while sweeping
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    if (accept) begin
      mem_re    = 1'b1;
      mem_raddr = is_sweep_op ? '0 : in_item_i.router_id[IDX_W-1:0];
    end else if (state_q == S_SWEEP && ptr_q != LAST_IDX) begin
      mem_re    = 1'b1;
      mem_raddr = ptr_q + 1'b1;
    end
  end

  // Next-state and result logic
  always_comb begin
    state_d   = state_q;
    valid_d   = valid_q;
    nbr_d     = nbr_q;
    recv_d    = recv_q;
    stale_d   = stale_q;
    dup_d     = dup_q;
    ptr_d     = ptr_q;
    cnt_d     = cnt_q;
    out_d     = '0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = mem_rdata;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ptr_d   = '0;
          cnt_d   = '0;
          state_d = is_sweep_op ? S_SWEEP : S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_d.status   = lste_pkg::ST_DONE;
          mem_waddr      = idx_q;
          case (op_q)
            lste_pkg::OP_INSTALL: begin
              if (!in_range_q) begin
                out_d.status = lste_pkg::ST_NOT_FOUND;
              end else if (found && seq_q < mem_rdata.seq) begin
                stale_d      = stale_q + 32'd1;
                out_d.status = lste_pkg::ST_STALE;
              end else if (found && seq_q == mem_rdata.seq) begin
                dup_d        = dup_q + 32'd1;
                out_d.status = lste_pkg::ST_DUPLICATE;
              end else begin
                mem_we         = 1'b1;
                mem_wdata.seq  = seq_q;
                mem_wdata.age  = age_q;
                valid_d[idx_q] = 1'b1;
                nbr_d[idx_q]   = 1'b1;
                recv_d         = recv_q + 32'd1;
                out_d.status   = lste_pkg::ST_ACCEPTED;
              end
            end
            lste_pkg::OP_REMOVE: begin
              if (found) begin
                valid_d[idx_q] = 1'b0;
                out_d.status   = lste_pkg::ST_REMOVED;
              end else begin
                out_d.status = lste_pkg::ST_NOT_FOUND;
              end
            end
            lste_pkg::OP_LOOKUP: begin
              if (found) begin
                out_d.seq_out = mem_rdata.seq;
                out_d.age_out = mem_rdata.age;
              end else begin
                out_d.status = lste_pkg::ST_NOT_FOUND;
              end
            end
            lste_pkg::OP_CLEAR: begin
              valid_d = '0;
              nbr_d   = '0;
            end
            default: begin
              out_d.status = lste_pkg::ST_DONE;
            end
          endcase
          // Per-router fields only for in-range ids of the single-entry operations
          if (in_range_q && (op_q == lste_pkg::OP_INSTALL ||
                             op_q == lste_pkg::OP_REMOVE ||
                             op_q == lste_pkg::OP_LOOKUP)) begin
            out_d.found        = found;
            out_d.is_neighbour = nbr_d[idx_q];
          end
          state_d = S_IDLE;
        end
      end

      S_SWEEP: begin
        // Process the entry whose data sits on the read port
        if (valid_q[ptr_q]) begin
          if (op_q == lste_pkg::OP_AGE) begin
            if (mem_rdata.age != lste_pkg::AGE_SAT) begin
              mem_we        = 1'b1;
              mem_wdata.age = mem_rdata.age + 16'd1;
            end
          end else if (mem_rdata.age >= max_age_q) begin
            valid_d[ptr_q] = 1'b0;
            cnt_d          = cnt_q + 1'b1;
          end
        end
        if (ptr_q == LAST_IDX) begin
          state_d = S_WRAP;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      S_WRAP: begin
        if (out_free) begin
          out_load            = 1'b1;
          stale_d             = stale_q + 32'(cnt_q);
          out_d.status        = lste_pkg::ST_DONE;
          out_d.flushed_count = cnt_q;
          state_d             = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_d.received_total  = recv_d;
    out_d.stale_total     = stale_d;
    out_d.duplicate_total = dup_d;
  end

  // Control state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      max_age_q   <= lste_pkg::MAX_AGE_RST;
      valid_q     <= '0;
      nbr_q       <= '0;
      recv_q      <= '0;
      stale_q     <= '0;
      dup_q       <= '0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      nbr_q   <= nbr_d;
      recv_q  <= recv_d;
      stale_q <= stale_d;
      dup_q   <= dup_d;
      ptr_q   <= ptr_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        max_age_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= in_item_i.operation;
      idx_q      <= in_item_i.router_id[IDX_W-1:0];
      in_range_q <= (32'(in_item_i.router_id) < MAX_ROUTERS);
      seq_q      <= in_item_i.seq_in;
      age_q      <= in_item_i.age_in;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Memory writes happen only while an item is being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_EXEC || state_q == S_SWEEP))
    else $error("memory write outside exec or sweep");

  // A result never overwrites one still waiting to be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrote a pending item");

  // An accepted item always leaves the idle state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("accepted item did not start work");

  // Sweep pointer stays inside the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) |-> (32'(ptr_q) <= DEPTH - 1))
    else $error("sweep pointer past last entry");

  // Flush count never exceeds the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= DEPTH)
    else $error("flush count overflow");

endmodule

`default_nettype wire

// File: src/lste_mem.sv
`default_nettype none

module lste_mem #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire lste_pkg::entry_t         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output lste_pkg::entry_t              rdata_o
);

  lste_pkg::entry_t mem [DEPTH];
  lste_pkg::entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
